// File: hw/rtl/video_ula_pixel_serializer_core_defines.svh
// ----------------------------------------------------------------------------
// video ula pixel serializer: assertion macros
// Shared property wrappers, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef VIDEO_ULA_PIXEL_SERIALIZER_CORE_DEFINES_SVH
`define VIDEO_ULA_PIXEL_SERIALIZER_CORE_DEFINES_SVH

// same-cycle implication
`define VUPS_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define VUPS_ASSERT_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: hw/rtl/vups_pkg.sv
// ----------------------------------------------------------------------------
// vups_pkg
// Word kinds, colour constants, shared types and helper functions.
// ----------------------------------------------------------------------------
package vups_pkg;

  // word kinds
  localparam logic [2:0] KIND_CONTROL = 3'd0;
  localparam logic [2:0] KIND_PALETTE = 3'd1;
  localparam logic [2:0] KIND_LOAD    = 3'd2;
  localparam logic [2:0] KIND_PIXELS  = 3'd3;
  localparam logic [2:0] KIND_BLANK   = 3'd4;

  // rgb channel masks
  localparam logic [11:0] PIX_MASK   = 12'hfff;
  localparam logic [11:0] RED_BITS   = 12'hf00;
  localparam logic [11:0] GREEN_BITS = 12'h0f0;
  localparam logic [11:0] BLUE_BITS  = 12'h00f;

  // cursor segment patterns
  localparam logic [7:0] CURSOR_SEG0 = 8'hf0;
  localparam logic [7:0] CURSOR_SEG1 = 8'h0c;
  localparam logic [7:0] CURSOR_SEG2 = 8'h03;

  // palette entries are stored already inverted
  localparam logic [3:0] PAL_INVERT = 4'h7;

  localparam int unsigned NUM_PIX = 8;
  localparam int unsigned NUM_PAL = 16;

  typedef logic [NUM_PAL-1:0][3:0]  palette_t;
  typedef logic [NUM_PIX-1:0][11:0] pixels_t;

  // register state seen by the pixel generator
  typedef struct packed {
    logic [7:0] control;
    logic [7:0] shift_byte;
    logic [7:0] cursor_shape;
  } state_t;

  // values handed back for the register update
  typedef struct packed {
    logic [7:0] shift_byte;
    logic [7:0] cursor_shape;
  } update_t;

  // cursor pattern from the three select bits
  function automatic logic [7:0] cursor_arm(input logic [2:0] sel);
    logic [7:0] r;
    r = '0;
    if (sel[0]) r = r | CURSOR_SEG0;
    if (sel[1]) r = r | CURSOR_SEG1;
    if (sel[2]) r = r | CURSOR_SEG2;
    return r;
  endfunction

  // physical colour to rgb, with flash inversion of the upper eight
  function automatic logic [11:0] phys_to_rgb(input logic [3:0] p, input logic flash);
    logic [2:0]  c;
    logic [11:0] v;
    c = p[2:0] ^ {3{p[3] & flash}};
    v = '0;
    if (c[0]) v = v | RED_BITS;
    if (c[1]) v = v | GREEN_BITS;
    if (c[2]) v = v | BLUE_BITS;
    return v;
  endfunction

endpackage

// File: hw/rtl/vups_regs.sv
// ----------------------------------------------------------------------------
// vups_regs
// Control, palette, shift byte and cursor shape registers, updated per word.
// ----------------------------------------------------------------------------
module vups_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               commit,
  input  logic [2:0]         kind,
  input  logic [7:0]         data,
  input  logic               cursor_display,
  input  vups_pkg::update_t  upd,
  output vups_pkg::state_t   state,
  output vups_pkg::palette_t palette
);

  logic [7:0]         control;
  logic [7:0]         shift_byte;
  logic [7:0]         cursor_shape;
  vups_pkg::palette_t colour_map;

  // register writes and emit side effects
  always_ff @(posedge clk) begin
    if (rst) begin
      control      <= '0;
      shift_byte   <= '0;
      cursor_shape <= '0;
      colour_map   <= '0;
    end else if (commit) begin
      case (kind)
        vups_pkg::KIND_CONTROL: begin
          control <= data;
        end
        vups_pkg::KIND_PALETTE: begin
          colour_map[data[7:4]] <= data[3:0] ^ vups_pkg::PAL_INVERT;
        end
        vups_pkg::KIND_LOAD: begin
          shift_byte <= data;
          if (cursor_display) cursor_shape <= vups_pkg::cursor_arm(control[7:5]);
        end
        vups_pkg::KIND_PIXELS: begin
          shift_byte   <= upd.shift_byte;
          cursor_shape <= upd.cursor_shape;
        end
        vups_pkg::KIND_BLANK: begin
          cursor_shape <= upd.cursor_shape;
        end
        default: begin
        end
      endcase
    end
  end

  assign state.control      = control;
  assign state.shift_byte   = shift_byte;
  assign state.cursor_shape = cursor_shape;
  assign palette            = colour_map;

endmodule

// File: hw/rtl/vups_pixgen.sv
// ----------------------------------------------------------------------------
// vups_pixgen
// Shifts logical pixels out of the byte, maps them through the palette and
// fills the eight output pixels, with flash and cursor applied.
// ----------------------------------------------------------------------------
module vups_pixgen (
  input  logic               blank,
  input  vups_pkg::state_t   state,
  input  vups_pkg::palette_t palette,
  output vups_pkg::pixels_t  pixels,
  output vups_pkg::update_t  upd
);

  logic [vups_pkg::NUM_PIX:0][7:0]  step_byte;
  logic [vups_pkg::NUM_PIX-1:0][11:0] step_rgb;
  logic [vups_pkg::NUM_PIX-1:0][3:0]  idx;
  logic [1:0]                         width;
  logic                               flash;
  logic                               cur_on;

  assign width  = state.control[3:2];
  assign flash  = state.control[0];
  assign cur_on = state.cursor_shape[0];

  // successive shift byte values, a one entering at the bottom
  always_comb begin
    step_byte[0] = state.shift_byte;
    for (int j = 0; j < vups_pkg::NUM_PIX; j++) begin
      step_byte[j+1] = {step_byte[j][6:0], 1'b1};
    end
  end

  // logical colour from bits 7,5,3,1 then palette lookup
  always_comb begin
    for (int j = 0; j < vups_pkg::NUM_PIX; j++) begin
      idx[j]      = {step_byte[j][7], step_byte[j][5], step_byte[j][3], step_byte[j][1]};
      step_rgb[j] = vups_pkg::phys_to_rgb(palette[idx[j]], flash);
    end
  end

  // repeat each logical pixel to fill the eight outputs
  always_comb begin
    for (int i = 0; i < vups_pkg::NUM_PIX; i++) begin
      case (width)
        2'd0:    pixels[i] = step_rgb[0];
        2'd1:    pixels[i] = step_rgb[i >> 2];
        2'd2:    pixels[i] = step_rgb[i >> 1];
        2'd3:    pixels[i] = step_rgb[i];
        default: pixels[i] = step_rgb[0];
      endcase
      if (blank) pixels[i] = '0;
      if (cur_on) pixels[i] = pixels[i] ^ vups_pkg::PIX_MASK;
    end
  end

  // shift byte after 1, 2, 4 or 8 pixels
  always_comb begin
    case (width)
      2'd0:    upd.shift_byte = step_byte[1];
      2'd1:    upd.shift_byte = step_byte[2];
      2'd2:    upd.shift_byte = step_byte[4];
      2'd3:    upd.shift_byte = step_byte[8];
      default: upd.shift_byte = step_byte[1];
    endcase
  end

  // cursor advances by one, or by two in fast clock mode
  assign upd.cursor_shape = state.control[4] ? (state.cursor_shape >> 2)
                                             : (state.cursor_shape >> 1);

endmodule

// File: hw/rtl/video_ula_pixel_serializer_core.sv
// ----------------------------------------------------------------------------
// video_ula_pixel_serializer_core
// Palette pixel serializer with hardware cursor, one word per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries words of kind, data and
//   cursor_display: control write, palette write, byte load, pixel emit or
//   blank emit. Writes and byte loads produce nothing on the output.
//   Output channel (out_valid/out_ready) carries one word of eight 12-bit
//   RGB pixels, pixel0..pixel7, for every pixel or blank emit.
//   An emit word is registered in the input register and its pixels then in
//   the result register, from which they show on the output.
//   Throughput: one word per cycle unless an emit waits on a stalled output,
//   set by the single input and result registers around one lookup and fill pass.
//   Register state updates as each word leaves the input register, so a
//   write is seen by the very next word.
//   Reset clears control, palette, shift byte and cursor, and empties both
//   registers. When the receiver stalls, the result is held; one further
//   word is taken into the input register and writes keep flowing past an
//   occupied output only if they produce no result.
// ----------------------------------------------------------------------------
`include "video_ula_pixel_serializer_core_defines.svh"

module video_ula_pixel_serializer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  data,
  input  logic        cursor_display,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] pixel0,
  output logic [11:0] pixel1,
  output logic [11:0] pixel2,
  output logic [11:0] pixel3,
  output logic [11:0] pixel4,
  output logic [11:0] pixel5,
  output logic [11:0] pixel6,
  output logic [11:0] pixel7
);

  logic                s1_valid;
  logic [2:0]          s1_kind;
  logic [7:0]          s1_data;
  logic                s1_cud;
  logic                s1_emit;
  logic                s1_blank;
  logic                s1_advance;
  vups_pkg::state_t    state;
  vups_pkg::palette_t  palette;
  vups_pkg::update_t   upd;
  vups_pkg::pixels_t   pix_calc;
  vups_pkg::pixels_t   pix;

  assign s1_blank   = (s1_kind == vups_pkg::KIND_BLANK);
  assign s1_emit    = (s1_kind == vups_pkg::KIND_PIXELS) || s1_blank;
  assign s1_advance = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind <= kind;
      s1_data <= data;
      s1_cud  <= cursor_display;
    end
  end

  vups_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .commit         (s1_advance),
    .kind           (s1_kind),
    .data           (s1_data),
    .cursor_display (s1_cud),
    .upd            (upd),
    .state          (state),
    .palette        (palette)
  );

  vups_pixgen u_pixgen (
    .blank   (s1_blank),
    .state   (state),
    .palette (palette),
    .pixels  (pix_calc),
    .upd     (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      pix <= pix_calc;
    end
  end

  assign pixel0 = pix[0];
  assign pixel1 = pix[1];
  assign pixel2 = pix[2];
  assign pixel3 = pix[3];
  assign pixel4 = pix[4];
  assign pixel5 = pix[5];
  assign pixel6 = pix[6];
  assign pixel7 = pix[7];

  // writes never wait on the output side
  `VUPS_ASSERT_NOW(a_write_flows, s1_valid && !s1_emit, s1_advance, "write word stalled")

  // an emit leaving the input register always lands in the result register
  `VUPS_ASSERT_NXT(a_emit_lands, s1_advance && s1_emit, out_valid, "emit result lost")

  // blank without cursor gives black pixels
  `VUPS_ASSERT_NXT(a_blank_black, s1_advance && s1_blank && !state.cursor_shape[0], (pixel0 == 12'h000) && (pixel7 == 12'h000), "blank not black")

  // an emit with cursor set always moves the cursor pattern down
  `VUPS_ASSERT_NXT(a_cursor_moves, s1_advance && s1_emit && state.cursor_shape[0], !state.cursor_shape[7], "cursor not shifted")

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: video_ula_pixel_serializer_core testbench
// Sends control, palette, byte load and emit words with random gaps on the
// input and random back-pressure on the output, and checks every output word
// of eight pixels against a predictor of the palette, shift and cursor state.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 1400;

  // one input word, or a marker that holds the sender until the output drains
  typedef struct {
    logic [2:0] kind;
    logic [7:0] data;
    logic       cud;
    bit         drain;
  } word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  kind = vups_pkg::KIND_CONTROL;
  logic [7:0]  data = 8'h00;
  logic        cursor_display = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] pixel0, pixel1, pixel2, pixel3, pixel4, pixel5, pixel6, pixel7;

  word_t             pending_words[$];
  vups_pkg::pixels_t expected_pixels[$];
  word_t             cur_word;
  bit                holding = 1'b0;
  int                n_sent = 0;
  int                n_err = 0;
  int                idle_cycles = 0;
  logic              steady;

  // predicted display state
  logic [7:0] ctrl_q;
  logic [3:0] cmap_q [vups_pkg::NUM_PAL];
  logic [7:0] sbyte_q;
  logic [7:0] cshape_q;

  video_ula_pixel_serializer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .kind           (kind),
    .data           (data),
    .cursor_display (cursor_display),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel0         (pixel0),
    .pixel1         (pixel1),
    .pixel2         (pixel2),
    .pixel3         (pixel3),
    .pixel4         (pixel4),
    .pixel5         (pixel5),
    .pixel6         (pixel6),
    .pixel7         (pixel7)
  );

  always #2 clk = ~clk;

  // no gaps on either side for a stretch in the middle of the run
  assign steady = (n_sent >= 600) && (n_sent < 950);

  // applies one word to the predicted state, returns 1 with pixels for emits
  function automatic bit render_word(input word_t w, output vups_pkg::pixels_t px);
    int         count;
    int         rep;
    logic [3:0] idx;
    logic [3:0] phys;
    logic [2:0] c;
    logic [11:0] v;
    px = '0;
    case (w.kind)
      vups_pkg::KIND_CONTROL: begin
        ctrl_q = w.data;
        return 1'b0;
      end
      vups_pkg::KIND_PALETTE: begin
        cmap_q[w.data[7:4]] = w.data[3:0] ^ vups_pkg::PAL_INVERT;
        return 1'b0;
      end
      vups_pkg::KIND_LOAD: begin
        sbyte_q = w.data;
        if (w.cud) begin
          cshape_q = '0;
          if (ctrl_q[5]) cshape_q = cshape_q | vups_pkg::CURSOR_SEG0;
          if (ctrl_q[6]) cshape_q = cshape_q | vups_pkg::CURSOR_SEG1;
          if (ctrl_q[7]) cshape_q = cshape_q | vups_pkg::CURSOR_SEG2;
        end
        return 1'b0;
      end
      vups_pkg::KIND_PIXELS: begin
        count = 1 << ctrl_q[3:2];
        rep = int'(vups_pkg::NUM_PIX) / count;
        for (int i = 0; i < count; i++) begin
          // logical colour from the odd bits, then shift in a one
          idx = {sbyte_q[7], sbyte_q[5], sbyte_q[3], sbyte_q[1]};
          sbyte_q = {sbyte_q[6:0], 1'b1};
          phys = cmap_q[idx];
          c = phys[2:0];
          if (phys[3] && ctrl_q[0]) c = c ^ 3'h7;
          v = {{4{c[0]}}, {4{c[1]}}, {4{c[2]}}};
          for (int k = 0; k < rep; k++) px[i * rep + k] = v;
        end
      end
      vups_pkg::KIND_BLANK: px = '0;
      default: return 1'b0;
    endcase
    // cursor inversion, then the cursor shape moves on
    if (cshape_q[0]) begin
      for (int i = 0; i < vups_pkg::NUM_PIX; i++) px[i] = px[i] ^ vups_pkg::PIX_MASK;
    end
    cshape_q = cshape_q >> (ctrl_q[4] ? 2 : 1);
    return 1'b1;
  endfunction

  // input driver
  always @(posedge clk) begin
    word_t             w;
    vups_pkg::pixels_t px;
    bit                fire;
    bit                go;
    if (rst) begin
      in_valid <= 1'b0;
      ctrl_q = '0;
      sbyte_q = '0;
      cshape_q = '0;
      for (int i = 0; i < vups_pkg::NUM_PAL; i++) cmap_q[i] = '0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        n_sent++;
        if (render_word(cur_word, px)) expected_pixels.push_back(px);
      end
      if (holding && expected_pixels.size() == 0) holding = 1'b0;
      if (!in_valid || fire) begin
        go = 1'b0;
        if (!holding && pending_words.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
          w = pending_words.pop_front();
          if (w.drain) begin
            holding = 1'b1;
          end else begin
            cur_word = w;
            go = 1'b1;
          end
        end
        in_valid <= go;
        if (go) begin
          kind <= w.kind;
          data <= w.data;
          cursor_display <= w.cud;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    vups_pkg::pixels_t got;
    vups_pkg::pixels_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {pixel7, pixel6, pixel5, pixel4, pixel3, pixel2, pixel1, pixel0};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          n_err++;
        end else begin
          want = expected_pixels.pop_front();
          for (int i = 0; i < vups_pkg::NUM_PIX; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: pixel%0d expected %03h actual %03h", $time, i, want[i], got[i]);
              n_err++;
            end
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 20);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("** video_ula_pixel_serializer_core: FAILED **");
        $finish;
      end
    end
  end

  int n_items = 0;

  task automatic queue_word(input logic [2:0] k, input logic [7:0] d, input logic cud);
    word_t w;
    w.kind = k;
    w.data = d;
    w.cud = cud;
    w.drain = 1'b0;
    pending_words.push_back(w);
    if (k <= vups_pkg::KIND_BLANK) n_items++;
  endtask

  task automatic queue_drain();
    word_t w;
    w.kind = vups_pkg::KIND_CONTROL;
    w.data = '0;
    w.cud = 1'b0;
    w.drain = 1'b1;
    pending_words.push_back(w);
  endtask

  initial begin
    int pick;
    int n_emit;
    int next_drain;

    // reset state, palette extremes, every line width, flash, cursor, fast clock
    queue_word(vups_pkg::KIND_BLANK, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_PIXELS, 8'hff, 1'b1);
    queue_word(vups_pkg::KIND_PALETTE, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_PALETTE, 8'hff, 1'b1);
    queue_word(vups_pkg::KIND_PALETTE, 8'ha5, 1'b0);
    queue_word(vups_pkg::KIND_CONTROL, 8'h0c, 1'b0);
    queue_word(vups_pkg::KIND_LOAD, 8'haa, 1'b0);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_CONTROL, 8'h0d, 1'b0);
    queue_word(vups_pkg::KIND_LOAD, 8'h55, 1'b0);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_CONTROL, 8'he0, 1'b0);
    queue_word(vups_pkg::KIND_LOAD, 8'haa, 1'b1);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_BLANK, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_CONTROL, 8'hf4, 1'b0);
    queue_word(vups_pkg::KIND_LOAD, 8'h00, 1'b1);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_BLANK, 8'h00, 1'b0);
    queue_word(vups_pkg::KIND_CONTROL, 8'h2a, 1'b0);
    queue_word(vups_pkg::KIND_LOAD, 8'h5a, 1'b1);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    // unused kinds are dropped without a word out
    queue_word(3'd5, 8'hff, 1'b1);
    queue_word(3'd6, 8'h0f, 1'b0);
    queue_word(3'd7, 8'hf0, 1'b1);
    queue_word(vups_pkg::KIND_PIXELS, 8'h00, 1'b0);
    queue_drain();

    // random part: mostly character cells, a load followed by a few emits
    n_items = 0;
    next_drain = 350;
    while (n_items < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        queue_word(vups_pkg::KIND_LOAD, 8'($urandom_range(255)), $urandom_range(9) < 3);
        n_emit = $urandom_range(3, 1);
        for (int i = 0; i < n_emit; i++) begin
          if ($urandom_range(9) < 8) begin
            queue_word(vups_pkg::KIND_PIXELS, 8'($urandom_range(255)),
                       1'($urandom_range(1)));
          end else begin
            queue_word(vups_pkg::KIND_BLANK, 8'($urandom_range(255)),
                       1'($urandom_range(1)));
          end
        end
      end else if (pick < 82) begin
        queue_word(vups_pkg::KIND_PALETTE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 90) begin
        queue_word(vups_pkg::KIND_CONTROL, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (pick < 97) begin
        queue_word(vups_pkg::KIND_BLANK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        queue_word(3'($urandom_range(7, 5)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
      end
      if (n_items >= next_drain) begin
        queue_drain();
        next_drain += 350;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for all words to go in and every expected word to come out
    while (pending_words.size() != 0 || in_valid || holding || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);

    if (n_err == 0) begin
      $display("** video_ula_pixel_serializer_core: PASSED **");
    end else begin
      $display("** video_ula_pixel_serializer_core: FAILED **");
    end
    $finish;
  end

endmodule
